/* rtl/mini_language_tokenizer_unit_defines.svh */
// assertion macros shared by the tokenizer modules
`ifndef MINI_LANGUAGE_TOKENIZER_UNIT_DEFINES_SVH
`define MINI_LANGUAGE_TOKENIZER_UNIT_DEFINES_SVH

// property that holds on every clock edge out of reset
`define MLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define MLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mlt_pkg.sv */
// types and constants of the mini language tokenizer
package mlt_pkg;

  localparam int LENGTH_BITS   = 16;
  localparam int OFFSET_BITS   = 32;
  localparam int OUT_OFFSET_W  = 32;
  localparam int OUT_LENGTH_W  = 16;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = 2;

  typedef enum logic [3:0] {
    KIND_INT     = 4'd0,
    KIND_PUNCT   = 4'd1,
    KIND_OP      = 4'd2,
    KIND_PAIR_OP = 4'd3,
    KIND_ASSIGN  = 4'd4,
    KIND_STRING  = 4'd5,
    KIND_TYPE    = 4'd6,
    KIND_KEYWORD = 4'd7,
    KIND_IDENT   = 4'd8,
    KIND_BAD     = 4'd9,
    KIND_OPEN    = 4'd10
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic [OUT_OFFSET_W-1:0]  start_offset;
    logic [OUT_LENGTH_W-1:0]  length;
    logic                     last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } step_out_t;

endpackage

/* rtl/mlt_step.sv */
// tokenizer scan state and per-character classification
`include "mini_language_tokenizer_unit_defines.svh"

module mlt_step
  import mlt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] ch_i,
  input  logic       is_end_i,
  output step_out_t  res_o
);

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_INT    = 3'd1;
  localparam logic [2:0] MODE_PAIR   = 3'd2;
  localparam logic [2:0] MODE_STRING = 3'd3;
  localparam logic [2:0] MODE_WORD   = 3'd4;

  localparam logic [39:0] WORD_INT   = 40'h00_0069_6E74;
  localparam logic [39:0] WORD_BOOL  = 40'h00_626F_6F6C;
  localparam logic [39:0] WORD_VOID  = 40'h00_766F_6964;
  localparam logic [39:0] WORD_WHILE = 40'h77_6869_6C65;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return (c == 8'h28) || (c == 8'h29) || (c == 8'h7B) || (c == 8'h7D) ||
           (c == 8'h20) || (c == 8'h0A) || (c == 8'h3B);
  endfunction

  function automatic logic is_single_op(logic [7:0] c);
    return (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2F) || (c == 8'h2A) || (c == 8'h25);
  endfunction

  function automatic logic is_pair_op(logic [7:0] c);
    return (c == 8'h3D) || (c == 8'h7C) || (c == 8'h26) || (c == 8'h3C) ||
           (c == 8'h3E) || (c == 8'h21);
  endfunction

  function automatic result_t mk(kind_e k, logic [OFFSET_BITS-1:0] offs,
                                 logic [LENGTH_BITS-1:0] len);
    logic [OFFSET_BITS+OUT_OFFSET_W-1:0] ow;
    logic [LENGTH_BITS+OUT_LENGTH_W-1:0] lw;
    result_t r;
    ow = {{OUT_OFFSET_W{1'b0}}, offs};
    lw = {{OUT_LENGTH_W{1'b0}}, len};
    r.kind         = k;
    r.start_offset = ow[OUT_OFFSET_W-1:0];
    r.length       = lw[OUT_LENGTH_W-1:0];
    r.last         = 1'b0;
    return r;
  endfunction

  logic [2:0]             mode_q, mode_d;
  logic [OFFSET_BITS-1:0] tstart_q, tstart_d;
  logic [LENGTH_BITS-1:0] tlen_q, tlen_d;
  logic                   peq_q, peq_d;
  logic [39:0]            prefix_q, prefix_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic                   halted_q, halted_d;

  logic [LENGTH_BITS-1:0] tlen_grown;
  kind_e                  word_kind;
  logic                   do_flush, at_end, do_begin;
  logic                   fl_v, bg_v, mid_v;
  result_t                fl_r, bg_r, mid_r;

  assign tlen_grown = (tlen_q == {LENGTH_BITS{1'b1}}) ? tlen_q : tlen_q + 1'b1;

  always_comb begin
    if ((tlen_q == LENGTH_BITS'(3)) && (prefix_q == WORD_INT)) begin
      word_kind = KIND_TYPE;
    end else if ((tlen_q == LENGTH_BITS'(4)) &&
                 ((prefix_q == WORD_BOOL) || (prefix_q == WORD_VOID))) begin
      word_kind = KIND_TYPE;
    end else if ((tlen_q == LENGTH_BITS'(5)) && (prefix_q == WORD_WHILE)) begin
      word_kind = KIND_KEYWORD;
    end else begin
      word_kind = KIND_IDENT;
    end
  end

  // decide what this character does to the scan state
  always_comb begin
    mode_d   = mode_q;
    tstart_d = tstart_q;
    tlen_d   = tlen_q;
    peq_d    = peq_q;
    prefix_d = prefix_q;
    pos_d    = pos_q;
    halted_d = halted_q;
    do_flush = 1'b0;
    at_end   = 1'b0;
    do_begin = 1'b0;
    mid_v    = 1'b0;
    mid_r    = mk(KIND_STRING, tstart_q, tlen_grown);
    if (fire_i) begin
      if (is_end_i) begin
        do_flush = !halted_q;
        at_end   = 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
        if (!halted_q) begin
          if ((mode_q == MODE_INT) && is_digit(ch_i)) begin
            tlen_d = tlen_grown;
          end else if ((mode_q == MODE_WORD) && is_letter(ch_i)) begin
            if (tlen_q < LENGTH_BITS'(5)) begin
              prefix_d = {prefix_q[31:0], ch_i};
            end
            tlen_d = tlen_grown;
          end else if (mode_q == MODE_STRING) begin
            tlen_d = tlen_grown;
            if (ch_i == 8'h22) begin
              mid_v  = 1'b1;
              mid_r  = mk(KIND_STRING, tstart_q, tlen_grown);
              mode_d = MODE_IDLE;
            end
          end else if ((mode_q == MODE_PAIR) && is_pair_op(ch_i)) begin
            mid_v  = 1'b1;
            mid_r  = mk(KIND_PAIR_OP, tstart_q, LENGTH_BITS'(2));
            mode_d = MODE_IDLE;
          end else begin
            do_flush = 1'b1;
            do_begin = 1'b1;
          end
        end
      end
    end

    // pending token closes
    fl_v = 1'b0;
    fl_r = mk(KIND_INT, tstart_q, tlen_q);
    if (do_flush) begin
      mode_d = MODE_IDLE;
      unique case (mode_q)
        MODE_INT: begin
          fl_v = 1'b1;
        end
        MODE_WORD: begin
          fl_v = 1'b1;
          fl_r = mk(word_kind, tstart_q, tlen_q);
        end
        MODE_PAIR: begin
          fl_v = 1'b1;
          fl_r = mk(peq_q ? KIND_ASSIGN : KIND_PAIR_OP, tstart_q, LENGTH_BITS'(1));
        end
        MODE_STRING: begin
          fl_v = at_end;
          fl_r = mk(KIND_OPEN, tstart_q, tlen_q);
        end
        default: begin
          fl_v = 1'b0;
        end
      endcase
    end

    // new token opens with this character
    bg_v = 1'b0;
    bg_r = mk(KIND_PUNCT, pos_q, LENGTH_BITS'(1));
    if (do_begin) begin
      tstart_d = pos_q;
      tlen_d   = LENGTH_BITS'(1);
      if (is_digit(ch_i)) begin
        mode_d = MODE_INT;
      end else if (is_punct(ch_i)) begin
        bg_v = 1'b1;
      end else if (is_single_op(ch_i)) begin
        bg_v = 1'b1;
        bg_r = mk(KIND_OP, pos_q, LENGTH_BITS'(1));
      end else if (is_pair_op(ch_i)) begin
        mode_d = MODE_PAIR;
        peq_d  = (ch_i == 8'h3D);
      end else if (ch_i == 8'h22) begin
        mode_d = MODE_STRING;
      end else if (is_letter(ch_i)) begin
        mode_d   = MODE_WORD;
        prefix_d = {32'b0, ch_i};
      end else begin
        bg_v     = 1'b1;
        bg_r     = mk(KIND_BAD, pos_q, LENGTH_BITS'(1));
        halted_d = 1'b1;
      end
    end

    // end mark restarts the stream
    if (fire_i && is_end_i) begin
      mode_d   = MODE_IDLE;
      tstart_d = '0;
      tlen_d   = '0;
      peq_d    = 1'b0;
      prefix_d = '0;
      pos_d    = '0;
      halted_d = 1'b0;
    end
  end

  always_comb begin
    res_o.cnt  = 2'd0;
    res_o.res0 = fl_r;
    res_o.res1 = bg_r;
    if (fl_v) begin
      res_o.cnt = bg_v ? 2'd2 : 2'd1;
    end else if (bg_v) begin
      res_o.cnt  = 2'd1;
      res_o.res0 = bg_r;
    end else if (mid_v) begin
      res_o.cnt  = 2'd1;
      res_o.res0 = mid_r;
    end
    res_o.res0.last = (res_o.cnt == 2'd1);
    res_o.res1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      tstart_q <= '0;
      tlen_q   <= '0;
      peq_q    <= 1'b0;
      prefix_q <= '0;
      pos_q    <= '0;
      halted_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      tstart_q <= tstart_d;
      tlen_q   <= tlen_d;
      peq_q    <= peq_d;
      prefix_q <= prefix_d;
      pos_q    <= pos_d;
      halted_q <= halted_d;
    end
  end

  `MLT_ASSERT(a_halt_quiet, (fire_i && halted_q) |-> (res_o.cnt == 2'd0), "result while halted")
  `MLT_ASSERT_NEXT(a_end_clears, fire_i && is_end_i, (mode_q == MODE_IDLE) && (pos_q == '0) && !halted_q, "end mark did not clear state")
  `MLT_ASSERT(a_pair_only_flush, (res_o.cnt == 2'd2) |-> do_flush, "two results without a flush")

endmodule

/* rtl/mlt_result_fifo.sv */
// result queue taking up to two tokens per transfer in
`include "mini_language_tokenizer_unit_defines.svh"

module mlt_result_fifo
  import mlt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  step_out_t push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output result_t   out_res_o
);

  result_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] rd_q, wr_q, wr_next;
  logic [FIFO_PTR_BITS:0]   cnt_q, cnt_d;
  logic                     pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = mem_q[rd_q];
  assign room_o      = (cnt_q <= (FIFO_PTR_BITS+1)'(FIFO_DEPTH - 2));
  assign wr_next     = wr_q + 1'b1;
  assign cnt_d       = cnt_q + (FIFO_PTR_BITS+1)'(push_i.cnt) - (FIFO_PTR_BITS+1)'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      wr_q  <= wr_q + FIFO_PTR_BITS'(push_i.cnt);
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.res1;
    end
  end

  `MLT_ASSERT(a_cnt_bound, cnt_q <= (FIFO_PTR_BITS+1)'(FIFO_DEPTH), "queue count past depth")
  `MLT_ASSERT(a_push_room, (push_i.cnt != 2'd0) |-> room_o, "push without room")
  `MLT_ASSERT_NEXT(a_pop_only, pop && (push_i.cnt == 2'd0), cnt_q == $past(cnt_q) - 1'b1, "count did not drop on pop")

endmodule

/* rtl/mini_language_tokenizer_unit.sv */
// top level of the mini language tokenizer
// Takes one source character per transfer (or an end mark) and reports tokens
// as kind, start offset and length, one result per output transfer; a
// character gives zero, one or two results. One character is taken every
// cycle while the queue has room: it is held in an input register, classified
// against the scan state there, and its results land in a four-entry result
// queue, so a character passes through the input register and the queue
// before its first result can leave. The input stalls only while that queue
// has fewer than two free entries.
module mini_language_tokenizer_unit
  import mlt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  input  logic        is_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  kind_o,
  output logic [31:0] start_offset_o,
  output logic [15:0] length_o,
  output logic        last_o
);

  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       is_end_q;
  logic       room;
  logic       fire;
  step_out_t  step_res;
  result_t    out_res;

  assign fire       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q     <= ch_i;
      is_end_q <= is_end_i;
    end
  end

  mlt_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .ch_i     (ch_q),
    .is_end_i (is_end_q),
    .res_o    (step_res)
  );

  mlt_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step_res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res)
  );

  assign kind_o         = out_res.kind;
  assign start_offset_o = out_res.start_offset;
  assign length_o       = out_res.length;
  assign last_o         = out_res.last;

endmodule
